// ===== src/brps_pkg.sv =====
// brps_pkg: shared types, codes and sizes for the block request page segmenter
// used by brps_check, brps_emit and block_request_page_segmenter
package brps_pkg;

	localparam int PAGE_BYTES_LOG2 = 12;
	localparam int MAX_SEGMENTS    = 11;

	localparam int ADDR_W   = 64;
	localparam int SECT_W   = 48;
	localparam int COUNT_W  = 16;
	localparam int SSL_W    = 4;
	localparam int CFG_W    = 48;
	localparam int IDX_W    = 3;
	localparam int FIELD_W  = 4;
	localparam int SEC_W    = 3;
	localparam int SEG_W    = $clog2(MAX_SEGMENTS + 1);
	localparam int LOG_W    = $clog2(PAGE_BYTES_LOG2 + 1);
	localparam int LEN_W    = COUNT_W + PAGE_BYTES_LOG2;
	localparam int SPAN_W   = LEN_W + 1;
	localparam int MIN_SSL  = 9;

	typedef enum logic [1:0] {
		MODE_READ    = 2'd0,
		MODE_WRITE   = 2'd1,
		MODE_FLUSH   = 2'd2,
		MODE_UNKNOWN = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOPERM  = 2'd1,
		ST_INVALID = 2'd2,
		ST_NOTSUP  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		OP_READ     = 2'd0,
		OP_WRITE    = 2'd1,
		OP_WBARRIER = 2'd2,
		OP_CFLUSH   = 2'd3
	} ring_op_t;

	typedef enum logic [IDX_W-1:0] {
		REG_DEVICE_SECTORS   = 3'd0,
		REG_MAX_SECTORS      = 3'd1,
		REG_READ_ONLY        = 3'd2,
		REG_SECTOR_SIZE_LOG2 = 3'd3,
		REG_BARRIER          = 3'd4,
		REG_CACHE_FLUSH      = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [SECT_W-1:0]  device_sectors;
		logic [COUNT_W-1:0] max_sectors;
		logic               read_only;
		logic [SSL_W-1:0]   sector_size_log2;
		logic               barrier_enabled;
		logic               cache_flush_enabled;
	} cfg_t;

	typedef struct packed {
		mode_t              mode;
		logic [ADDR_W-1:0]  buf_addr;
		logic [SECT_W-1:0]  start_lba;
		logic [COUNT_W-1:0] sector_count;
	} req_t;

	// one checked request, ready to be split into results
	typedef struct packed {
		status_t            status;
		ring_op_t           op;
		logic [SEG_W-1:0]   seg_count;
		logic [SEG_W-1:0]   nres;
		logic [ADDR_W-1:0]  page;
		logic [SEC_W-1:0]   first;
		logic [SEC_W-1:0]   last_tail;
		logic [SEC_W-1:0]   last_full;
		logic [SECT_W-1:0]  sector;
	} desc_t;

	typedef struct packed {
		status_t             status;
		ring_op_t            op;
		logic [FIELD_W-1:0]  seg_count;
		logic [FIELD_W-1:0]  seg_index;
		logic [ADDR_W-1:0]   page;
		logic [SEC_W-1:0]    first;
		logic [SEC_W-1:0]    last;
		logic [SECT_W-1:0]   sector;
		logic                last_in_run;
	} result_t;

endpackage

// ===== src/block_request_page_segmenter.sv =====
// block_request_page_segmenter: top level, config registers and request register
// depends on brps_pkg, brps_check and brps_emit
//
// Usage: one request word enters on mode/buffer_address/start_lba/sector_count
// under in_valid/in_ready. Each request gives one or more result words under
// out_valid/out_ready: one per page segment of a good read or write, or a single
// word for a flush, an unknown mode or a failed check (last_in_run marks the end).
// A request passes the request register, the emitter's descriptor register and
// the output register before its first word shows at out_valid. Throughput: one
// result word per cycle while out_ready is high, set by the emitter's segment
// counter (1 to 11 segments a request); single-result requests go one per cycle.
// The request register takes a new word while the emitter still works on the
// previous request and the output register holds a word.
// A stall on out_ready holds the output word and backs up into in_ready.
// Registers are written through cfg_write/cfg_index/cfg_data; the user must do so
// only while idle, which the block does not enforce. Reset clears all valid flags
// and sets the registers to reset values (sector_size_log2 to 9, the rest to 0).
module block_request_page_segmenter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [brps_pkg::IDX_W-1:0]    cfg_index,
	input  logic [brps_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    mode,
	input  logic [brps_pkg::ADDR_W-1:0]   buffer_address,
	input  logic [brps_pkg::SECT_W-1:0]   start_lba,
	input  logic [brps_pkg::COUNT_W-1:0]  sector_count,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    status,
	output logic [1:0]                    ring_operation,
	output logic [brps_pkg::FIELD_W-1:0]  segment_count,
	output logic [brps_pkg::FIELD_W-1:0]  segment_index,
	output logic [brps_pkg::ADDR_W-1:0]   page_address,
	output logic [brps_pkg::SEC_W-1:0]    first_sector,
	output logic [brps_pkg::SEC_W-1:0]    last_sector,
	output logic [brps_pkg::SECT_W-1:0]   ring_lba,
	output logic                          last_in_run
);
	import brps_pkg::*;

	cfg_t    cfg_q;
	req_t    req_s1;
	logic    valid_s1;
	desc_t   desc;
	logic    desc_ready;
	result_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{device_sectors: '0, max_sectors: '0, read_only: 1'b0,
				sector_size_log2: SSL_W'(MIN_SSL), barrier_enabled: 1'b0,
				cache_flush_enabled: 1'b0};
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_DEVICE_SECTORS:   cfg_q.device_sectors      <= cfg_data[SECT_W-1:0];
				REG_MAX_SECTORS:      cfg_q.max_sectors         <= cfg_data[COUNT_W-1:0];
				REG_READ_ONLY:        cfg_q.read_only           <= cfg_data[0];
				REG_SECTOR_SIZE_LOG2: cfg_q.sector_size_log2    <= cfg_data[SSL_W-1:0];
				REG_BARRIER:          cfg_q.barrier_enabled     <= cfg_data[0];
				REG_CACHE_FLUSH:      cfg_q.cache_flush_enabled <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign in_ready = !valid_s1 || desc_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1.mode         <= mode_t'(mode);
			req_s1.buf_addr     <= buffer_address;
			req_s1.start_lba    <= start_lba;
			req_s1.sector_count <= sector_count;
		end
	end

	brps_check u_check (
		.req  (req_s1),
		.cfg  (cfg_q),
		.desc (desc)
	);

	brps_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.desc_valid (valid_s1),
		.desc_ready (desc_ready),
		.desc       (desc),
		.res_valid  (out_valid),
		.res_ready  (out_ready),
		.res        (res)
	);

	assign status         = res.status;
	assign ring_operation = res.op;
	assign segment_count  = res.seg_count;
	assign segment_index  = res.seg_index;
	assign page_address   = res.page;
	assign first_sector   = res.first;
	assign last_sector    = res.last;
	assign ring_lba       = res.sector;
	assign last_in_run    = res.last_in_run;

endmodule

// ===== src/brps_check.sv =====
// brps_check: validates one registered request and builds its descriptor
// depends on brps_pkg
module brps_check (
	input  brps_pkg::req_t  req,
	input  brps_pkg::cfg_t  cfg,
	output brps_pkg::desc_t desc
);
	import brps_pkg::*;

	logic [LOG_W-1:0]           ssl;
	logic [LEN_W-1:0]           len;
	logic [ADDR_W-1:0]          align_mask;
	logic [ADDR_W:0]            end_sum;
	logic [PAGE_BYTES_LOG2-1:0] off;
	logic [SPAN_W-1:0]          span;
	logic [SPAN_W-1:0]          nseg;
	logic [SECT_W:0]            range_end;
	logic [PAGE_BYTES_LOG2:0]   per_page;
	logic                       any_err;

	always_comb begin
		// clamp sector size to 512 .. page size
		if (cfg.sector_size_log2 < SSL_W'(MIN_SSL))
			ssl = LOG_W'(MIN_SSL);
		else if (LOG_W'(cfg.sector_size_log2) > LOG_W'(PAGE_BYTES_LOG2))
			ssl = LOG_W'(PAGE_BYTES_LOG2);
		else
			ssl = LOG_W'(cfg.sector_size_log2);

		len        = LEN_W'(req.sector_count) << ssl;
		align_mask = (ADDR_W'(1) << ssl) - ADDR_W'(1);
		end_sum    = {1'b0, req.buf_addr} + (ADDR_W+1)'(len) - (ADDR_W+1)'(1);
		off        = req.buf_addr[PAGE_BYTES_LOG2-1:0];
		// page span from the in-page offset, narrow instead of full address
		span       = SPAN_W'(off) + SPAN_W'(len) - SPAN_W'(1);
		nseg       = (span >> PAGE_BYTES_LOG2) + SPAN_W'(1);
		range_end  = {1'b0, req.start_lba} + (SECT_W+1)'(req.sector_count);
		per_page   = ((PAGE_BYTES_LOG2+1)'(1) << PAGE_BYTES_LOG2) >> ssl;

		any_err = (req.buf_addr == '0) ||
			(req.sector_count == '0) ||
			(range_end > {1'b0, cfg.device_sectors}) ||
			(req.sector_count > cfg.max_sectors) ||
			((req.buf_addr & align_mask) != '0) ||
			end_sum[ADDR_W] ||
			(nseg > SPAN_W'(MAX_SEGMENTS));

		desc = '0;
		desc.status = ST_OK;
		desc.op     = OP_READ;
		desc.nres   = SEG_W'(1);

		priority if (req.mode == MODE_UNKNOWN) begin
			desc.status = ST_INVALID;
		end else if (req.mode == MODE_FLUSH) begin
			if (cfg.barrier_enabled)
				desc.op = OP_WBARRIER;
			else if (cfg.cache_flush_enabled)
				desc.op = OP_CFLUSH;
			else
				desc.status = ST_NOTSUP;
		end else if (req.mode == MODE_WRITE && cfg.read_only) begin
			desc.status = ST_NOPERM;
		end else if (any_err) begin
			desc.status = ST_INVALID;
		end else begin
			desc.op        = (req.mode == MODE_WRITE) ? OP_WRITE : OP_READ;
			desc.seg_count = SEG_W'(nseg);
			desc.nres      = SEG_W'(nseg);
			desc.page      = {req.buf_addr[ADDR_W-1:PAGE_BYTES_LOG2],
				PAGE_BYTES_LOG2'(0)};
			desc.first     = SEC_W'(off >> ssl);
			desc.last_tail = SEC_W'(span[PAGE_BYTES_LOG2-1:0] >> ssl);
			desc.last_full = SEC_W'(per_page - (PAGE_BYTES_LOG2+1)'(1));
			desc.sector    = req.start_lba;
		end
	end

endmodule

// ===== src/brps_emit.sv =====
// brps_emit: holds one descriptor and emits its results, one per cycle while
// res_ready takes them, through a registered output word; depends on brps_pkg
module brps_emit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              desc_valid,
	output logic              desc_ready,
	input  brps_pkg::desc_t   desc,
	output logic              res_valid,
	input  logic              res_ready,
	output brps_pkg::result_t res
);
	import brps_pkg::*;

	logic              busy_q;
	desc_t             desc_q;
	logic [SEG_W-1:0]  idx_q;
	logic [ADDR_W-1:0] page_q;
	logic              out_valid_q;
	result_t           res_q;
	result_t           res_nxt;
	logic              out_free;
	logic              emit;
	logic              is_last;
	logic              last_emit;
	logic              take;

	always_comb begin
		is_last    = (idx_q == desc_q.nres - SEG_W'(1));
		out_free   = !out_valid_q || res_ready;
		emit       = busy_q && out_free;
		last_emit  = emit && is_last;
		desc_ready = !busy_q || last_emit;
		take       = desc_valid && desc_ready;

		res_nxt             = '0;
		res_nxt.status      = desc_q.status;
		res_nxt.op          = desc_q.op;
		res_nxt.seg_count   = FIELD_W'(desc_q.seg_count);
		res_nxt.seg_index   = FIELD_W'(idx_q);
		res_nxt.page        = page_q;
		res_nxt.first       = (idx_q == '0) ? desc_q.first : SEC_W'(0);
		res_nxt.last        = is_last ? desc_q.last_tail : desc_q.last_full;
		res_nxt.sector      = desc_q.sector;
		res_nxt.last_in_run = is_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take)
				busy_q <= 1'b1;
			else if (last_emit)
				busy_q <= 1'b0;
			if (emit)
				out_valid_q <= 1'b1;
			else if (res_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			desc_q <= desc;
			idx_q  <= '0;
			page_q <= desc.page;
		end else if (emit) begin
			idx_q  <= idx_q + SEG_W'(1);
			// next page of the buffer
			page_q <= page_q + (ADDR_W'(1) << PAGE_BYTES_LOG2);
		end
		if (emit)
			res_q <= res_nxt;
	end

	assign res_valid = out_valid_q;
	assign res       = res_q;

`ifndef ASSERT_OFF
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (idx_q < desc_q.nres))
		else $error("segment index past result count");

	a_stay_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && !is_last) |=> busy_q)
		else $error("descriptor dropped before its last segment");

	a_multi_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !res_q.last_in_run) |-> (res_q.status == ST_OK))
		else $error("error result not marked last");

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.last_in_run && res_q.seg_count != '0) |->
		(res_q.seg_index == res_q.seg_count - FIELD_W'(1)))
		else $error("last segment index mismatch");
`endif

endmodule

// ===== dv/brps_ring_check.sv =====
// brps_ring_check: watches the config port and both word channels of the page segmenter,
// predicts every result word and compares it with the word taken from the block
// depends on brps_pkg
`timescale 1ns / 100ps

module brps_ring_check (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [brps_pkg::IDX_W-1:0]    cfg_index,
	input  logic [brps_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic [1:0]                    mode,
	input  logic [brps_pkg::ADDR_W-1:0]   buffer_address,
	input  logic [brps_pkg::SECT_W-1:0]   start_lba,
	input  logic [brps_pkg::COUNT_W-1:0]  sector_count,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [1:0]                    status,
	input  logic [1:0]                    ring_operation,
	input  logic [brps_pkg::FIELD_W-1:0]  segment_count,
	input  logic [brps_pkg::FIELD_W-1:0]  segment_index,
	input  logic [brps_pkg::ADDR_W-1:0]   page_address,
	input  logic [brps_pkg::SEC_W-1:0]    first_sector,
	input  logic [brps_pkg::SEC_W-1:0]    last_sector,
	input  logic [brps_pkg::SECT_W-1:0]   ring_lba,
	input  logic                          last_in_run,
	output int                            mismatches,
	output int                            words_due
);
	import brps_pkg::*;

	cfg_t    regs;
	result_t ring_words[$];
	result_t want;
	result_t got;

	function automatic void push_error(status_t code);
		result_t r;
		r = '0;
		r.status = code;
		r.last_in_run = 1'b1;
		ring_words.push_back(r);
	endfunction

	// turns one request into its ring words, error word or flush word
	function automatic void segment_request(mode_t m, logic [63:0] buf_a, logic [47:0] start,
			logic [15:0] cnt);
		result_t     r;
		int unsigned shift;
		logic [63:0] pg_bytes, pg_mask, start64, cnt64, len, last_byte, nseg, first, last;
		pg_bytes = 64'd1 << PAGE_BYTES_LOG2;
		pg_mask = pg_bytes - 64'd1;
		start64 = {16'd0, start};
		cnt64 = {48'd0, cnt};
		shift = {28'd0, regs.sector_size_log2};
		if (shift < MIN_SSL)
			shift = MIN_SSL;
		if (shift > PAGE_BYTES_LOG2)
			shift = PAGE_BYTES_LOG2;
		r = '0;
		r.last_in_run = 1'b1;
		if (m == MODE_UNKNOWN) begin
			push_error(ST_INVALID);
			return;
		end
		if (m == MODE_FLUSH) begin
			if (regs.barrier_enabled)
				r.op = OP_WBARRIER;
			else if (regs.cache_flush_enabled)
				r.op = OP_CFLUSH;
			else
				r.status = ST_NOTSUP;
			ring_words.push_back(r);
			return;
		end
		if (m == MODE_WRITE && regs.read_only) begin
			push_error(ST_NOPERM);
			return;
		end
		if (buf_a == 64'd0 || cnt == 16'd0 || start64 + cnt64 > {16'd0, regs.device_sectors}
				|| cnt > regs.max_sectors || (buf_a & ((64'd1 << shift) - 64'd1)) != 64'd0) begin
			push_error(ST_INVALID);
			return;
		end
		len = cnt64 << shift;
		last_byte = buf_a + (len - 64'd1);
		if (last_byte < buf_a) begin
			push_error(ST_INVALID);
			return;
		end
		nseg = (last_byte >> PAGE_BYTES_LOG2) - (buf_a >> PAGE_BYTES_LOG2) + 64'd1;
		if (nseg > 64'(MAX_SEGMENTS)) begin
			push_error(ST_INVALID);
			return;
		end
		for (longint unsigned k = 0; k < nseg; k++) begin
			first = (k == 0) ? ((buf_a & pg_mask) >> shift) : 64'd0;
			last = (k == nseg - 1) ? ((last_byte & pg_mask) >> shift)
				: ((pg_bytes >> shift) - 64'd1);
			r.status = ST_OK;
			r.op = (m == MODE_WRITE) ? OP_WRITE : OP_READ;
			r.seg_count = nseg[FIELD_W-1:0];
			r.seg_index = k[FIELD_W-1:0];
			r.page = (buf_a & ~pg_mask) + k * pg_bytes;
			r.first = first[SEC_W-1:0];
			r.last = last[SEC_W-1:0];
			r.sector = start;
			r.last_in_run = (k == nseg - 1);
			ring_words.push_back(r);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs = '0;
			regs.sector_size_log2 = SSL_W'(MIN_SSL);
			ring_words.delete();
		end else begin
			if (cfg_write) begin
				case (reg_idx_t'(cfg_index))
				REG_DEVICE_SECTORS:   regs.device_sectors = cfg_data[SECT_W-1:0];
				REG_MAX_SECTORS:      regs.max_sectors = cfg_data[COUNT_W-1:0];
				REG_READ_ONLY:        regs.read_only = cfg_data[0];
				REG_SECTOR_SIZE_LOG2: regs.sector_size_log2 = cfg_data[SSL_W-1:0];
				REG_BARRIER:          regs.barrier_enabled = cfg_data[0];
				REG_CACHE_FLUSH:      regs.cache_flush_enabled = cfg_data[0];
				default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				got.status = status_t'(status);
				got.op = ring_op_t'(ring_operation);
				got.seg_count = segment_count;
				got.seg_index = segment_index;
				got.page = page_address;
				got.first = first_sector;
				got.last = last_sector;
				got.sector = ring_lba;
				got.last_in_run = last_in_run;
				if (ring_words.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: word with none expected: st=%0d op=%0d page=%h",
							$realtime, got.status, got.op, got.page);
					mismatches++;
				end else begin
					want = ring_words.pop_front();
					if (got.status !== want.status || got.op !== want.op
							|| got.seg_count !== want.seg_count
							|| got.seg_index !== want.seg_index || got.page !== want.page
							|| got.first !== want.first || got.last !== want.last
							|| got.sector !== want.sector
							|| got.last_in_run !== want.last_in_run) begin
						if (mismatches < 10) begin
							$display("%0t: word mismatch", $realtime);
							$display(
								"  expected st=%0d op=%0d cnt=%0d idx=%0d page=%h",
								want.status, want.op, want.seg_count, want.seg_index,
								want.page);
							$display("           first=%0d last=%0d sect=%h fin=%0d",
								want.first, want.last, want.sector, want.last_in_run);
							$display(
								"  actual   st=%0d op=%0d cnt=%0d idx=%0d page=%h",
								got.status, got.op, got.seg_count, got.seg_index,
								got.page);
							$display("           first=%0d last=%0d sect=%h fin=%0d",
								got.first, got.last, got.sector, got.last_in_run);
						end
						mismatches++;
					end
				end
			end
			if (in_valid && in_ready)
				segment_request(mode_t'(mode), buffer_address, start_lba, sector_count);
		end
		words_due = ring_words.size();
	end

endmodule

// ===== dv/testbench.sv =====
// testbench: drives requests and register settings into block_request_page_segmenter
// and gives the verdict; prediction and compare live in brps_ring_check
`timescale 1ns / 100ps

module testbench;
	import brps_pkg::*;

	logic                clk;
	logic                arst_n;
	logic                cfg_write;
	logic [IDX_W-1:0]    cfg_index;
	logic [CFG_W-1:0]    cfg_data;
	logic                in_valid;
	logic                in_ready;
	logic [1:0]          mode;
	logic [ADDR_W-1:0]   buffer_address;
	logic [SECT_W-1:0]   start_lba;
	logic [COUNT_W-1:0]  sector_count;
	logic                out_valid;
	logic                out_ready;
	logic [1:0]          status;
	logic [1:0]          ring_operation;
	logic [FIELD_W-1:0]  segment_count;
	logic [FIELD_W-1:0]  segment_index;
	logic [ADDR_W-1:0]   page_address;
	logic [SEC_W-1:0]    first_sector;
	logic [SEC_W-1:0]    last_sector;
	logic [SECT_W-1:0]   ring_lba;
	logic                last_in_run;
	int                  mismatches;
	int                  words_due;

	cfg_t        live_cfg;
	bit          calm;
	int unsigned ready_hold;

	block_request_page_segmenter dut (.*);
	brps_ring_check watch (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// receiver: after each taken word, hold ready low for a drawn number of cycles
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_hold = 0;
			out_ready <= 1'b0;
		end else if (out_valid && out_ready) begin
			ready_hold = calm ? 0 : $urandom_range(0, 16);
			out_ready <= (ready_hold == 0);
		end else if (ready_hold != 0) begin
			ready_hold = ready_hold - 1;
			out_ready <= (ready_hold == 0);
		end else
			out_ready <= 1'b1;
	end

	task automatic write_regs(cfg_t c);
		live_cfg = c;
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= REG_DEVICE_SECTORS;
		cfg_data <= c.device_sectors;
		@(posedge clk);
		cfg_index <= REG_MAX_SECTORS;
		cfg_data <= {32'd0, c.max_sectors};
		@(posedge clk);
		cfg_index <= REG_READ_ONLY;
		cfg_data <= {47'd0, c.read_only};
		@(posedge clk);
		cfg_index <= REG_SECTOR_SIZE_LOG2;
		cfg_data <= {44'd0, c.sector_size_log2};
		@(posedge clk);
		cfg_index <= REG_BARRIER;
		cfg_data <= {47'd0, c.barrier_enabled};
		@(posedge clk);
		cfg_index <= REG_CACHE_FLUSH;
		cfg_data <= {47'd0, c.cache_flush_enabled};
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	// returns at the edge that takes the word, with valid still high
	task automatic issue(mode_t m, logic [63:0] b, logic [47:0] s, logic [15:0] c);
		int unsigned gap;
		gap = calm ? 0 : $urandom_range(0, 16);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		buffer_address <= b;
		start_lba <= s;
		sector_count <= c;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (words_due != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// mostly well-formed reads and writes sized for the live settings, the rest broken
	task automatic random_request();
		int unsigned pick, shift, cap;
		logic [63:0] b, s, dev;
		logic [15:0] c;
		mode_t       m;
		shift = {28'd0, live_cfg.sector_size_log2};
		if (shift < MIN_SSL)
			shift = MIN_SSL;
		if (shift > PAGE_BYTES_LOG2)
			shift = PAGE_BYTES_LOG2;
		dev = {16'd0, live_cfg.device_sectors};
		m = $urandom_range(0, 1) ? MODE_WRITE : MODE_READ;
		b = {$urandom, $urandom} & ~((64'd1 << shift) - 64'd1);
		if (b == 64'd0)
			b = 64'd1 << shift;
		cap = MAX_SEGMENTS << (PAGE_BYTES_LOG2 - shift);
		if ({16'd0, live_cfg.max_sectors} < cap)
			cap = {16'd0, live_cfg.max_sectors};
		if (cap == 0)
			cap = 1;
		c = 16'($urandom_range(1, cap));
		s = {$urandom, $urandom};
		if (dev >= {48'd0, c})
			s = s % (dev - {48'd0, c} + 64'd1);
		pick = $urandom_range(0, 99);
		if (pick < 8)
			m = MODE_FLUSH;
		else if (pick < 12)
			m = MODE_UNKNOWN;
		else if (pick < 30) begin
			case ($urandom_range(0, 6))
			0: begin
				m = mode_t'($urandom_range(0, 3));
				b = {$urandom, $urandom};
				c = 16'($urandom);
			end
			1: b = 64'd0;
			2: c = 16'd0;
			3: b = b | (64'd1 << $urandom_range(0, shift - 1));
			4: s = dev;
			5: c = 16'($urandom_range(12 << (PAGE_BYTES_LOG2 - shift), 65535));
			default: begin
				b = 64'hFFFF_FFFF_FFFF_F000 | (b & 64'hFFF);
				c = 16'($urandom_range(1, 64));
			end
			endcase
		end
		issue(m, b, s[47:0], c);
	endtask

	initial begin
		cfg_t c;
		arst_n = 1'b0;
		calm = 1'b0;
		cfg_write <= 1'b0;
		cfg_index <= REG_DEVICE_SECTORS;
		cfg_data <= '0;
		in_valid <= 1'b0;
		mode <= MODE_READ;
		buffer_address <= '0;
		start_lba <= '0;
		sector_count <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// 512-byte sectors, barrier on: good words, page edges and each failed check
		write_regs({48'hFFFF_FFFF_FFFF, 16'd128, 1'b0, 4'd9, 1'b1, 1'b0});
		issue(MODE_READ, 64'h1000, 48'd0, 16'd1);
		issue(MODE_WRITE, 64'h2000_0000_0000_0000, 48'd100, 16'd88);
		issue(MODE_WRITE, 64'h2000_0000_0000_0200, 48'd100, 16'd87);
		issue(MODE_WRITE, 64'h2000_0000_0000_0200, 48'd100, 16'd88);
		issue(MODE_READ, 64'hFFFF_FFFF_FFFF_F000, 48'hFFFF_FFFF_FFF0, 16'd8);
		issue(MODE_READ, 64'hFFFF_FFFF_FFFF_FE00, 48'd0, 16'd2);
		issue(MODE_UNKNOWN, {$urandom, $urandom}, 48'h5555_AAAA_5555, 16'hFFFF);
		issue(MODE_FLUSH, 64'h1000, 48'd7, 16'd3);
		issue(MODE_READ, 64'd0, 48'd0, 16'd1);
		issue(MODE_READ, 64'h1000, 48'd0, 16'd0);
		issue(MODE_READ, 64'h1000, 48'hFFFF_FFFF_FFFF, 16'd1);
		issue(MODE_READ, 64'h1000, 48'd0, 16'd129);
		issue(MODE_READ, 64'h1100, 48'd0, 16'd1);
		issue(MODE_WRITE, 64'h8000_0000_0000_0000, 48'd0, 16'hFFFF);
		settle();

		// read-only device, 4 KiB sectors, cache flush only
		write_regs({48'd1000, 16'hFFFF, 1'b1, 4'd12, 1'b0, 1'b1});
		issue(MODE_WRITE, 64'h4000, 48'd0, 16'd1);
		issue(MODE_READ, 64'h5000, 48'd989, 16'd11);
		issue(MODE_READ, 64'h5000, 48'd0, 16'd12);
		issue(MODE_FLUSH, 64'd0, 48'd0, 16'd0);
		issue(MODE_READ, 64'h5200, 48'd0, 16'd1);
		issue(MODE_READ, 64'h5000, 48'd990, 16'd11);
		settle();

		// sector size below range is taken as 512, no flush support
		write_regs({48'hFFFF_FFFF_FFFF, 16'hFFFF, 1'b0, 4'd0, 1'b0, 1'b0});
		issue(MODE_FLUSH, 64'd0, 48'd0, 16'd0);
		issue(MODE_WRITE, 64'h7E00, 48'h1234_5678_9ABC, 16'd3);
		issue(MODE_READ, 64'h1000, 48'd0, 16'hFFFF);
		settle();

		// sector size above range is taken as the page size
		write_regs({48'hFFFF_FFFF_FFFF, 16'hFFFF, 1'b0, 4'd15, 1'b1, 1'b1});
		issue(MODE_FLUSH, 64'd0, 48'd0, 16'd0);
		issue(MODE_READ, 64'h3000, 48'd5, 16'd2);
		settle();

		write_regs({48'd5000, 16'd40, 1'b0, 4'd10, 1'b0, 1'b1});
		issue(MODE_READ, 64'h0C00, 48'd4995, 16'd5);
		settle();

		for (int p = 0; p < 8; p++) begin
			case ($urandom_range(0, 5))
			0: c.device_sectors = 48'hFFFF_FFFF_FFFF;
			1: c.device_sectors = 48'($urandom_range(0, 64));
			2: c.device_sectors = 48'($urandom_range(100, 5000));
			default: c.device_sectors = 48'({$urandom, $urandom});
			endcase
			case ($urandom_range(0, 5))
			0: c.max_sectors = 16'hFFFF;
			1: c.max_sectors = 16'd0;
			default: c.max_sectors = 16'($urandom_range(1, 200));
			endcase
			c.read_only = ($urandom_range(0, 3) == 0);
			c.sector_size_log2 = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
				: 4'($urandom_range(MIN_SSL, PAGE_BYTES_LOG2));
			c.barrier_enabled = 1'($urandom_range(0, 1));
			c.cache_flush_enabled = 1'($urandom_range(0, 1));
			calm = ($urandom_range(0, 3) == 0);
			write_regs(c);
			repeat (25) random_request();
			settle();
		end

		if (mismatches == 0 && words_due == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== sim.f =====
src/brps_pkg.sv
src/brps_check.sv
src/brps_emit.sv
src/block_request_page_segmenter.sv
dv/brps_ring_check.sv
dv/testbench.sv
